/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/bfg_pkg.sv */
// ---------------------------------------------------------------------------
// Battery fuel gauge package
// Payload types, register indexes, level table and shared widths.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfg_pkg;

    localparam int ADC_W      = 12;
    localparam int TIME_W     = 32;
    localparam int MV_W       = 16;
    localparam int PCT_W      = 7;
    localparam int FACTOR_W   = 24;
    localparam int DELTA_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = ADC_W + FACTOR_W;
    localparam int DIV_NUM_W  = 12;
    localparam int DIV_DEN_W  = 8;
    localparam int TABLE_LEN  = 8;
    localparam int TBL_IDX_W  = 3;

    localparam logic [FACTOR_W-1:0] FACTOR_RST   = 24'd105625;
    localparam logic [DELTA_W-1:0]  RISE_RST     = 10'd50;
    localparam logic [DELTA_W-1:0]  FALL_RST     = 10'd10;
    localparam logic [TIME_W-1:0]   INTERVAL_RST = 32'd5000;
    localparam logic [PCT_W-1:0]    LOW_PCT_RST  = 7'd10;

    // Level table, highest voltage first.
    localparam logic [MV_W-1:0] LVL_MV [TABLE_LEN] = '{
        16'd3780, 16'd3600, 16'd3400, 16'd3200,
        16'd3000, 16'd2800, 16'd2600, 16'd2550
    };
    localparam logic [PCT_W-1:0] LVL_PCT [TABLE_LEN] = '{
        7'd100, 7'd80, 7'd60, 7'd40, 7'd20, 7'd10, 7'd5, 7'd1
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MV_PER_COUNT = 3'd0,
        REG_CHARGE_RISE  = 3'd1,
        REG_CHARGE_FALL  = 3'd2,
        REG_INTERVAL     = 3'd3,
        REG_LOW_LEVEL    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [ADC_W-1:0]  adc_sample;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [MV_W-1:0]  millivolts;
        logic [PCT_W-1:0] level_percent;
        logic             low_battery;
        logic             charging;
    } result_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

/* rtl/bfg_div.sv */
// ---------------------------------------------------------------------------
// Bit-serial divider
// Restoring divide, one quotient bit per cycle, done pulse at the end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfg_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bfg_pkg::div_req_t req,
    output bfg_pkg::div_rsp_t rsp
);
    import bfg_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_NUM_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_NUM_W-1:0] q_reg, q_next;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    always_comb
    begin
        trial = {rem_reg, q_reg[DIV_NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.den;
            q_next    = req.num;
        end
        else if (busy_reg)
        begin
            // shift in the next numerator bit, subtract where it fits
            rem_next = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            q_next   = {q_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            q_reg    <= q_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;

endmodule

/* rtl/battery_fuel_gauge.sv */
// A sample is accepted only in the idle state; sample_stall stays high while
// it runs through the 12-step bit-serial multiply and 12-step bit-serial
// divide, so a new sample cannot enter before the last one is through.
// The result register lets the next sample enter while a result waits.
// Reset: asynchronous, active low; registers return to their defaults and
// the charging state, reference and check time clear to zero.
// ---------------------------------------------------------------------------
// Battery fuel gauge
// Scales ADC samples to millivolts, maps them to a charge level and tracks
// charging against a periodically refreshed reference voltage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_fuel_gauge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  bfg_pkg::sample_t                    sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output bfg_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bfg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bfg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bfg_pkg::*;

    localparam int STEP_W = $clog2(ADC_W);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(ADC_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_SEG,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    sample_t              item_reg, item_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [MV_W-1:0]      mv_reg, mv_next;
    logic [PCT_W-1:0]     base_reg, base_next;
    logic                 result_valid_reg, result_valid_next;
    result_t              result_reg, result_next;

    logic [FACTOR_W-1:0]  factor_reg, factor_next;
    logic [DELTA_W-1:0]   rise_reg, rise_next;
    logic [DELTA_W-1:0]   fall_reg, fall_next;
    logic [TIME_W-1:0]    interval_reg, interval_next;
    logic [PCT_W-1:0]     low_pct_reg, low_pct_next;

    logic [MV_W-1:0]      ref_mv_reg, ref_mv_next;
    logic [TIME_W-1:0]    last_check_reg, last_check_next;
    logic                 charging_reg, charging_next;
    logic                 seen_first_reg, seen_first_next;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic [FACTOR_W:0]    mul_sum;
    logic [TBL_IDX_W-1:0] seg;
    logic [MV_W-1:0]      seg_off;
    logic [MV_W-1:0]      seg_span;
    logic [PCT_W-1:0]     seg_dpct;
    logic [DIV_NUM_W:0]   seg_num;
    logic                 seg_top;
    logic                 seg_bottom;
    logic [TIME_W-1:0]    elapsed;
    logic                 do_check;
    logic                 rise_hit;
    logic                 drop_hit;
    logic [PCT_W-1:0]     level;
    logic                 out_free;

    bfg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        // shift-add multiply step: multiplier bits leave at the bottom
        mul_sum = {1'b0, prod_reg[PROD_W-1:ADC_W]} + (prod_reg[0] ? {1'b0, factor_reg} : '0);

        seg_top    = (mv_reg >= LVL_MV[0]);
        seg_bottom = (mv_reg <= LVL_MV[TABLE_LEN-1]);
        seg        = TBL_IDX_W'(1);
        for (int k = TABLE_LEN - 1; k >= 1; k--)
        begin
            if (mv_reg >= LVL_MV[k])
            begin
                seg = TBL_IDX_W'(k);
            end
        end
        seg_off  = mv_reg - LVL_MV[seg];
        seg_span = LVL_MV[seg - 1'b1] - LVL_MV[seg];
        seg_dpct = LVL_PCT[seg - 1'b1] - LVL_PCT[seg];
        seg_num  = seg_off[DIV_DEN_W-1:0] * seg_dpct[4:0];

        elapsed  = item_reg.now_ms - last_check_reg;
        do_check = (elapsed > interval_reg);
        rise_hit = ({1'b0, mv_reg} > ({1'b0, ref_mv_reg} + {{(MV_W-DELTA_W+1){1'b0}}, rise_reg}));
        drop_hit = (({1'b0, mv_reg} + {{(MV_W-DELTA_W+1){1'b0}}, fall_reg}) < {1'b0, ref_mv_reg});
        level    = base_reg + div_rsp.quo[PCT_W-1:0];
        out_free = !result_valid_reg || !result_stall;

        state_next        = state_reg;
        step_next         = step_reg;
        item_next         = item_reg;
        prod_next         = prod_reg;
        mv_next           = mv_reg;
        base_next         = base_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        factor_next       = factor_reg;
        rise_next         = rise_reg;
        fall_next         = fall_reg;
        interval_next     = interval_reg;
        low_pct_next      = low_pct_reg;
        ref_mv_next       = ref_mv_reg;
        last_check_next   = last_check_reg;
        charging_next     = charging_reg;
        seen_first_next   = seen_first_reg;
        div_req.start     = 1'b0;
        div_req.num       = '0;
        div_req.den       = DIV_DEN_W'(1);

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MV_PER_COUNT: factor_next   = cfg_data[FACTOR_W-1:0];
                REG_CHARGE_RISE:  rise_next     = cfg_data[DELTA_W-1:0];
                REG_CHARGE_FALL:  fall_next     = cfg_data[DELTA_W-1:0];
                REG_INTERVAL:     interval_next = cfg_data[TIME_W-1:0];
                REG_LOW_LEVEL:    low_pct_next  = cfg_data[PCT_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    item_next  = sample;
                    prod_next  = {{FACTOR_W{1'b0}}, sample.adc_sample};
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = {mul_sum, prod_reg[ADC_W-1:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                // drop the 16 fraction bits, saturate to 16 bits
                if (|prod_reg[PROD_W-1:MV_W+16])
                begin
                    mv_next = '1;
                end
                else
                begin
                    mv_next = prod_reg[MV_W+15:16];
                end
                state_next = ST_SEG;
            end
            ST_SEG:
            begin
                div_req.start = 1'b1;
                if (seg_top)
                begin
                    base_next = LVL_PCT[0];
                end
                else if (seg_bottom)
                begin
                    base_next = LVL_PCT[TABLE_LEN-1];
                end
                else
                begin
                    base_next   = LVL_PCT[seg];
                    div_req.num = seg_num[DIV_NUM_W-1:0];
                    div_req.den = seg_span[DIV_DEN_W-1:0];
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    result_next.millivolts    = mv_reg;
                    result_next.level_percent = level;
                    result_next.low_battery   = (level <= low_pct_reg);
                    result_next.charging      = charging_reg;
                    if (do_check)
                    begin
                        if (rise_hit)
                        begin
                            charging_next            = 1'b1;
                            result_next.charging     = 1'b1;
                        end
                        else if (drop_hit)
                        begin
                            charging_next            = 1'b0;
                            result_next.charging     = 1'b0;
                        end
                        ref_mv_next     = mv_reg;
                        last_check_next = item_reg.now_ms;
                    end
                    if (!seen_first_reg)
                    begin
                        ref_mv_next     = mv_reg;
                        seen_first_next = 1'b1;
                    end
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            item_reg         <= '0;
            prod_reg         <= '0;
            mv_reg           <= '0;
            base_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            factor_reg       <= FACTOR_RST;
            rise_reg         <= RISE_RST;
            fall_reg         <= FALL_RST;
            interval_reg     <= INTERVAL_RST;
            low_pct_reg      <= LOW_PCT_RST;
            ref_mv_reg       <= '0;
            last_check_reg   <= '0;
            charging_reg     <= 1'b0;
            seen_first_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            item_reg         <= item_next;
            prod_reg         <= prod_next;
            mv_reg           <= mv_next;
            base_reg         <= base_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
            factor_reg       <= factor_next;
            rise_reg         <= rise_next;
            fall_reg         <= fall_next;
            interval_reg     <= interval_next;
            low_pct_reg      <= low_pct_next;
            ref_mv_reg       <= ref_mv_next;
            last_check_reg   <= last_check_next;
            charging_reg     <= charging_next;
            seen_first_reg   <= seen_first_next;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/bfg_checker.sv */
// ---------------------------------------------------------------------------
// Battery fuel gauge checker
// Port-level properties of the gauge, attached to the top level by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfg_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input logic             result_valid,
    input logic             result_stall,
    input bfg_pkg::result_t result
);
    import bfg_pkg::*;

    // one item in flight: an accepted sample closes the input
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, sample_valid && !sample_stall, sample_stall)

    `ASSERT_IMPLY(a_level_range, clk, rst_n, result_valid, (result.level_percent >= 7'd1) && (result.level_percent <= 7'd100))

    `ASSERT_IMPLY(a_level_full, clk, rst_n, result_valid && (result.millivolts >= LVL_MV[0]), result.level_percent == LVL_PCT[0])

    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind battery_fuel_gauge bfg_checker u_bfg_checker (.*);
